// ----- src/cli_pkg.sv -----
`default_nettype none

package cli_pkg;

	localparam int CLI_TABLE_DEPTH   = 256;
	localparam int CLI_FRACTION_BITS = 8;

	// APB register map, word index = paddr[3:2]
	localparam int CLI_PADDR_W = 4;
	localparam logic [1:0] REG_RANGE_LOW   = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH  = 2'd1;
	localparam logic [1:0] REG_INDEX_SCALE = 2'd2;
	localparam logic [1:0] REG_ENTRIES     = 2'd3;

	localparam logic signed [15:0] RANGE_LOW_RST   = 16'sd0;
	localparam logic signed [15:0] RANGE_HIGH_RST  = 16'sd255;
	localparam logic [23:0]        INDEX_SCALE_RST = 24'd65536;
	localparam logic [8:0]         ENTRIES_RST     = 9'd256;

	typedef struct packed {
		logic signed [15:0] range_low;
		logic signed [15:0] range_high;
		logic [23:0]        index_scale;
		logic [8:0]         entries_in_use;
	} cfg_t;

endpackage

`default_nettype wire

// ----- src/cli_ram.sv -----
`default_nettype none

module cli_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/cli_index.sv -----
`default_nettype none

// Stages s1 and s2: clamp and offset, scale multiply, then entry selection.
module cli_index #(
	parameter int TABLE_DEPTH   = cli_pkg::CLI_TABLE_DEPTH,
	parameter int FRACTION_BITS = cli_pkg::CLI_FRACTION_BITS,
	localparam int AW           = $clog2(TABLE_DEPTH)
) (
	input  wire logic                     clk,
	input  wire cli_pkg::cfg_t            cfg,
	input  wire logic                     ld_s1,
	input  wire logic                     ld_s2,
	input  wire logic                     req_type,
	input  wire logic signed [15:0]       sample,
	input  wire logic [7:0]               entry_index,
	input  wire logic [7:0]               entry_red,
	input  wire logic [7:0]               entry_green,
	input  wire logic [7:0]               entry_blue,
	output logic                          lookup_s2,
	output logic                          wr_hit,
	output logic [AW-1:0]                 wr_addr,
	output logic [23:0]                   wr_data,
	output logic [AW-1:0]                 rd_addr0,
	output logic [AW-1:0]                 rd_addr1,
	output logic [FRACTION_BITS-1:0]      frac
);

	logic signed [15:0] clamped;
	logic signed [16:0] diff;
	logic [15:0]        span;

	logic        lookup_s1;
	logic [15:0] span_s1;
	logic [7:0]  widx_s1;
	logic [23:0] wdata_s1;

	logic [39:0] pos_s2;
	logic [7:0]  widx_s2;
	logic [23:0] wdata_s2;

	logic [AW-1:0] last;
	logic [23:0]   ipart;

	// low bound tested first; an inverted range yields a negative offset, saturated to zero
	always_comb begin
		if (sample < cfg.range_low) begin
			clamped = cfg.range_low;
		end else if (sample > cfg.range_high) begin
			clamped = cfg.range_high;
		end else begin
			clamped = sample;
		end
		diff = {clamped[15], clamped} - {cfg.range_low[15], cfg.range_low};
		span = diff[16] ? 16'd0 : diff[15:0];
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			lookup_s1 <= req_type;
			span_s1   <= span;
			widx_s1   <= entry_index;
			wdata_s1  <= {entry_red, entry_green, entry_blue};
		end
		if (ld_s2) begin
			lookup_s2 <= lookup_s1;
			pos_s2    <= {24'd0, span_s1} * {16'd0, cfg.index_scale};
			widx_s2   <= widx_s1;
			wdata_s2  <= wdata_s1;
		end
	end

	assign wr_hit  = ({24'd0, widx_s2} < 32'(TABLE_DEPTH));
	assign wr_addr = AW'(widx_s2);
	assign wr_data = wdata_s2;

	// last usable entry: count saturated to [1, TABLE_DEPTH]
	always_comb begin
		if (cfg.entries_in_use == 9'd0) begin
			last = '0;
		end else if ({23'd0, cfg.entries_in_use} > 32'(TABLE_DEPTH)) begin
			last = AW'(TABLE_DEPTH - 1);
		end else begin
			last = AW'(cfg.entries_in_use - 9'd1);
		end
	end

	assign ipart = pos_s2[39:16];

	always_comb begin
		if (ipart >= 24'(last)) begin
			rd_addr0 = last;
			rd_addr1 = last;
			frac     = '0;
		end else begin
			rd_addr0 = ipart[AW-1:0];
			rd_addr1 = ipart[AW-1:0] + AW'(1);
			frac     = pos_s2[15 -: FRACTION_BITS];
		end
	end

endmodule

`default_nettype wire

// ----- src/cli_blend.sv -----
`default_nettype none

// Output stage: per-channel linear mix, rounded to nearest (ties up), registered.
module cli_blend #(
	parameter int FRACTION_BITS = cli_pkg::CLI_FRACTION_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     ld,
	input  wire logic [FRACTION_BITS-1:0] frac,
	input  wire logic [23:0]              entry0,
	input  wire logic [23:0]              entry1,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue
);

	localparam int FB = FRACTION_BITS;
	localparam int MW = FB + 9;
	localparam logic [FB:0] ONE  = (FB + 1)'(1) << FB;
	localparam logic [FB:0] HALF = (FB + 1)'(1) << (FB - 1);

	logic [FB:0] w0;
	logic [7:0]  chan_q [3];

	assign w0 = ONE - {1'b0, frac};

	for (genvar k = 0; k < 3; k++) begin : g_chan
		logic [MW-1:0] acc;

		assign acc = MW'(entry0[8*k +: 8]) * MW'(w0)
			+ MW'(entry1[8*k +: 8]) * MW'(frac) + MW'(HALF);

		always_ff @(posedge clk) begin
			if (ld) begin
				chan_q[k] <= acc[FB +: 8];
			end
		end
	end

	assign red   = chan_q[2];
	assign green = chan_q[1];
	assign blue  = chan_q[0];

endmodule

`default_nettype wire

// ----- src/color_lut_interpolator_unit.sv -----
// Colormap lookup with linear interpolation. Each input word either writes one
// 24-bit RGB table entry (req_type 0, no result) or looks up a sample (req_type 1,
// one result word). The block takes one word per clock unless in_stall is high, and a
// lookup passes stages s1, s2 and s3 before the output register; the table sits in two
// single-read-port RAMs holding identical copies, so both neighbouring entries
// are read in the same cycle. Table writes land in the RAMs in the same stage
// where lookups read them, so a lookup always sees every earlier write, with no
// stall. Table contents are undefined until written and need no clearing after
// reset. Registers (32-bit APB, byte addresses): 0x0 range_low, 0x4 range_high,
// 0x8 index_scale (Q8.16), 0xC entries_in_use; write them only while idle.
`default_nettype none

module color_lut_interpolator_unit #(
	parameter int TABLE_DEPTH   = cli_pkg::CLI_TABLE_DEPTH,
	parameter int FRACTION_BITS = cli_pkg::CLI_FRACTION_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [cli_pkg::CLI_PADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            req_type,
	input  wire logic signed [15:0]              sample,
	input  wire logic [7:0]                      entry_index,
	input  wire logic [7:0]                      entry_red,
	input  wire logic [7:0]                      entry_green,
	input  wire logic [7:0]                      entry_blue,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [7:0]                           red,
	output logic [7:0]                           green,
	output logic [7:0]                           blue
);

	localparam int AW = $clog2(TABLE_DEPTH);

	cli_pkg::cfg_t cfg_q;

	logic v1_q, v2_q, v3_q, vo_q;
	logic rdy1, rdy2, rdy3, rdyo;
	logic move2, rd_fire;

	logic                     lookup_s2;
	logic                     wr_hit;
	logic [AW-1:0]            wr_addr;
	logic [23:0]              wr_data;
	logic [AW-1:0]            rd_addr0, rd_addr1;
	logic [FRACTION_BITS-1:0] frac;
	logic [FRACTION_BITS-1:0] frac_s3;
	logic [23:0]              entry0_s3, entry1_s3;

	// ---------------- configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low      <= cli_pkg::RANGE_LOW_RST;
			cfg_q.range_high     <= cli_pkg::RANGE_HIGH_RST;
			cfg_q.index_scale    <= cli_pkg::INDEX_SCALE_RST;
			cfg_q.entries_in_use <= cli_pkg::ENTRIES_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				cli_pkg::REG_RANGE_LOW:   cfg_q.range_low      <= pwdata[15:0];
				cli_pkg::REG_RANGE_HIGH:  cfg_q.range_high     <= pwdata[15:0];
				cli_pkg::REG_INDEX_SCALE: cfg_q.index_scale    <= pwdata[23:0];
				cli_pkg::REG_ENTRIES:     cfg_q.entries_in_use <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cli_pkg::REG_RANGE_LOW:   prdata = {16'd0, cfg_q.range_low};
			cli_pkg::REG_RANGE_HIGH:  prdata = {16'd0, cfg_q.range_high};
			cli_pkg::REG_INDEX_SCALE: prdata = {8'd0, cfg_q.index_scale};
			cli_pkg::REG_ENTRIES:     prdata = {23'd0, cfg_q.entries_in_use};
			default:                  prdata = '0;
		endcase
	end

	// ---------------- pipeline control
	// a stage takes a new word when empty or when its word moves on;
	// table writes retire at s2 and never wait for s3
	assign rdyo    = !vo_q || !out_stall;
	assign rdy3    = !v3_q || rdyo;
	assign move2   = v2_q && (!lookup_s2 || rdy3);
	assign rdy2    = !v2_q || move2;
	assign rdy1    = !v1_q || rdy2;
	assign rd_fire = move2 && lookup_s2;

	assign in_stall  = !rdy1;
	assign out_valid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= in_valid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q && lookup_s2;
			end
			if (rdyo) begin
				vo_q <= v3_q;
			end
		end
	end

	// ---------------- datapath
	cli_index #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_index (
		.clk         (clk),
		.cfg         (cfg_q),
		.ld_s1       (rdy1),
		.ld_s2       (rdy2),
		.req_type    (req_type),
		.sample      (sample),
		.entry_index (entry_index),
		.entry_red   (entry_red),
		.entry_green (entry_green),
		.entry_blue  (entry_blue),
		.lookup_s2   (lookup_s2),
		.wr_hit      (wr_hit),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr0    (rd_addr0),
		.rd_addr1    (rd_addr1),
		.frac        (frac)
	);

	// both copies take every write; each serves one neighbour
	cli_ram #(
		.WIDTH (24),
		.DEPTH (TABLE_DEPTH)
	) u_ram0 (
		.clk   (clk),
		.we    (move2 && !lookup_s2 && wr_hit),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_fire),
		.raddr (rd_addr0),
		.rdata (entry0_s3)
	);

	cli_ram #(
		.WIDTH (24),
		.DEPTH (TABLE_DEPTH)
	) u_ram1 (
		.clk   (clk),
		.we    (move2 && !lookup_s2 && wr_hit),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_fire),
		.raddr (rd_addr1),
		.rdata (entry1_s3)
	);

	always_ff @(posedge clk) begin
		if (rd_fire) begin
			frac_s3 <= frac;
		end
	end

	cli_blend #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_blend (
		.clk    (clk),
		.ld     (v3_q && rdyo),
		.frac   (frac_s3),
		.entry0 (entry0_s3),
		.entry1 (entry1_s3),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

endmodule

`default_nettype wire

// ----- src/cli_checker.sv -----
`default_nettype none

module cli_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       req_type,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({red, green, blue}))
		else $error("stalled result word changed");

	// input back-pressure only comes from a full pipe behind a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("pipeline not empty after reset");

	// an unobstructed lookup reaches the output after passing stages s1, s2 and s3
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && req_type && !out_stall) ##1 !out_stall
		##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("lookup result missing at nominal latency");

endmodule

bind color_lut_interpolator_unit cli_checker u_cli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red       (red),
	.green     (green),
	.blue      (blue)
);

`default_nettype wire
